[sv/gbb_pkg.sv]
// Shared constants, codes and types of the grid bounding box detector.
`default_nettype none

package gbb_pkg;

   // Default frame limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Field widths
   localparam int PIXEL_W    = 8;
   localparam int LEVEL_W    = 8;
   localparam int DIM_W      = 11;
   localparam int MARGIN_W   = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 11;
   localparam int LEFT_W     = 10;
   localparam int SIZE_W     = 11;

   // Column entry: white run count plus the sticky qualified flag on top
   localparam int RUN_W   = 10;
   localparam int ENTRY_W = RUN_W + 1;
   localparam logic [RUN_W-1:0] RUN_SAT = '1;

   // Coordinates between the column unit and the box math cover the widest frame
   localparam int COORD_W = 12;
   localparam int SUM_W   = COORD_W + 1;

   // Result stream packing
   localparam int RSP_FIELDS_W = 2 * LEFT_W + 2 * SIZE_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // Register reset values
   localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH    = 11'd640;
   localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT   = 11'd480;
   localparam logic [DIM_W-1:0]    RST_RUN_THRESHOLD  = 11'd60;
   localparam logic [MARGIN_W-1:0] RST_EXPAND_MARGIN  = 10'd5;
   localparam logic [LEVEL_W-1:0]  RST_BINARIZE_LEVEL = 8'd125;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_RUN_THRESHOLD  = 3'd2,
      CSR_EXPAND_MARGIN  = 3'd3,
      CSR_BINARIZE_LEVEL = 3'd4
   } csr_index_type;

   // Edges of one finished frame, handed from the column unit to the box math
   typedef struct packed {
      logic               found;
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] bottom;
   } frame_edges_type;

endpackage : gbb_pkg

`default_nettype wire

[sv/gbb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port; a read of the same address in the same cycle returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : gbb_ram

`default_nettype wire

[sv/gbb_column_unit.sv]
// Raster position tracking, per-column run memory update and edge search.
`default_nettype none

module gbb_column_unit #(
   parameter int MAX_WIDTH  = gbb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gbb_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                pixel_accept,
   input  wire logic [gbb_pkg::PIXEL_W-1:0]         pixel_red,
   input  wire logic [gbb_pkg::LEVEL_W-1:0]         binarize_level,
   input  wire logic [gbb_pkg::DIM_W-1:0]           run_threshold,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      frame_width,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]     frame_height,
   output logic                                     frame_done,
   output gbb_pkg::frame_edges_type                 frame_edges
);

   import gbb_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WC_W  = $clog2(MAX_WIDTH + 1) + 1;
   localparam int HC_W  = $clog2(MAX_HEIGHT + 1) + 1;

   // Raster position of the next pixel
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;
   logic [WC_W-1:0]  col_sum;
   logic [HC_W-1:0]  row_sum;
   logic             last_col;
   logic             last_row;

   // Stage 1: pixel waiting for its column entry
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_x_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_row0_ff;
   logic             s1_last_row_ff;
   logic             s1_end_ff;
   logic             s1_black_ff;

   // Forwarding of a write that collides with the read of the next pixel
   logic               fwd_hit_ff, fwd_hit_in;
   logic [ENTRY_W-1:0] fwd_data_ff;

   // Column memory access
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] base_entry;
   logic [RUN_W-1:0]   run_old;
   logic               qual_old;
   logic [DIM_W-1:0]   run_inc;
   logic [RUN_W-1:0]   run_new;
   logic               qual_new;

   // Edge search state
   logic             left_ok_ff, right_ok_ff, top_ok_ff, bottom_ok_ff;
   logic             left_ok_in, right_ok_in, top_ok_in, bottom_ok_in;
   logic [COL_W-1:0] left_ff, right_ff, left_in, right_in;
   logic [ROW_W-1:0] top_ff, bottom_ff, top_in, bottom_in;

   // Row and frame ends follow the current size
   assign col_sum  = WC_W'(col_pos_ff) + WC_W'(1);
   assign row_sum  = HC_W'(row_pos_ff) + HC_W'(1);
   assign last_col = col_sum >= WC_W'(frame_width);
   assign last_row = row_sum >= HC_W'(frame_height);

   // Advance the raster position on each transfer
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (pixel_accept) begin
         priority if (!last_col) begin
            col_pos_in = col_sum[COL_W-1:0];
         end else if (!last_row) begin
            col_pos_in = '0;
            row_pos_in = row_sum[ROW_W-1:0];
         end else begin
            col_pos_in = '0;
            row_pos_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff  <= '0;
         row_pos_ff  <= '0;
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         col_pos_ff  <= col_pos_in;
         row_pos_ff  <= row_pos_in;
         s1_valid_ff <= pixel_accept;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   // Capture the pixel context while its column entry is read
   always_ff @(posedge clock) begin
      if (pixel_accept) begin
         s1_x_ff        <= col_pos_ff;
         s1_row_ff      <= row_pos_ff;
         s1_row0_ff     <= (row_pos_ff == '0);
         s1_last_row_ff <= last_row;
         s1_end_ff      <= last_col && last_row;
         s1_black_ff    <= pixel_red < binarize_level;
      end
      fwd_data_ff <= wr_data;
   end

   // Forward when stage 1 writes the column that is read in the same cycle
   assign fwd_hit_in = pixel_accept && s1_valid_ff && (s1_x_ff == col_pos_ff);

   gbb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WIDTH)
   ) u_column_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (wr_data),
      .rd_en   (pixel_accept),
      .rd_addr (col_pos_ff),
      .rd_data (rd_data)
   );

   // Update the white run and qualified flag of the column
   always_comb begin
      base_entry = fwd_hit_ff ? fwd_data_ff : rd_data;
      run_old    = s1_row0_ff ? '0 : base_entry[RUN_W-1:0];
      qual_old   = !s1_row0_ff && base_entry[RUN_W];
      run_inc    = DIM_W'(run_old) + DIM_W'(1);
      if (s1_black_ff) begin
         run_new  = '0;
         qual_new = qual_old;
      end else begin
         qual_new = qual_old || (run_inc >= run_threshold);
         run_new  = (run_inc > DIM_W'(RUN_SAT)) ? RUN_SAT : run_inc[RUN_W-1:0];
      end
      wr_data = {qual_new, run_new};
   end

   // Track first and last open column on the last row, first and last dark row
   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      left_ok_in   = left_ok_ff;
      right_ok_in  = right_ok_ff;
      top_ok_in    = top_ok_ff;
      bottom_ok_in = bottom_ok_ff;
      if (s1_valid_ff) begin
         if (s1_last_row_ff && !qual_new) begin
            if (!left_ok_ff) begin
               left_in    = s1_x_ff;
               left_ok_in = 1'b1;
            end
            right_in    = s1_x_ff;
            right_ok_in = 1'b1;
         end
         if (s1_black_ff) begin
            if (!top_ok_ff) begin
               top_in    = s1_row_ff;
               top_ok_in = 1'b1;
            end
            bottom_in    = s1_row_ff;
            bottom_ok_in = 1'b1;
         end
      end
   end

   // Hand the final edges over on the last pixel
   assign frame_done         = s1_valid_ff && s1_end_ff;
   assign frame_edges.found  = left_ok_in && right_ok_in && top_ok_in && bottom_ok_in;
   assign frame_edges.left   = COORD_W'(left_in);
   assign frame_edges.right  = COORD_W'(right_in);
   assign frame_edges.top    = COORD_W'(top_in);
   assign frame_edges.bottom = COORD_W'(bottom_in);

   // Clear the search at frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ok_ff   <= 1'b0;
         right_ok_ff  <= 1'b0;
         top_ok_ff    <= 1'b0;
         bottom_ok_ff <= 1'b0;
      end else if (frame_done) begin
         left_ok_ff   <= 1'b0;
         right_ok_ff  <= 1'b0;
         top_ok_ff    <= 1'b0;
         bottom_ok_ff <= 1'b0;
      end else begin
         left_ok_ff   <= left_ok_in;
         right_ok_ff  <= right_ok_in;
         top_ok_ff    <= top_ok_in;
         bottom_ok_ff <= bottom_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      right_ff  <= right_in;
      top_ff    <= top_in;
      bottom_ff <= bottom_in;
   end

   // A forwarded word always serves the pixel now in stage 1
   a_fwd_needs_pixel : assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff)
      else $error("forward hit without a pixel in stage 1");

   // The edge search restarts after each frame
   a_search_cleared : assert property (@(posedge clock) disable iff (reset)
      frame_done |=> !left_ok_ff && !right_ok_ff && !top_ok_ff && !bottom_ok_ff)
      else $error("edge search not cleared after frame end");

endmodule : gbb_column_unit

`default_nettype wire

[sv/gbb_box_calc.sv]
// Margin widening, clamping and size math of the detected box, with result register.
`default_nettype none

module gbb_box_calc (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                frame_done,
   input  wire gbb_pkg::frame_edges_type            frame_edges,
   input  wire logic [gbb_pkg::MARGIN_W-1:0]        expand_margin,
   input  wire logic [gbb_pkg::COORD_W-1:0]         col_last,
   input  wire logic [gbb_pkg::COORD_W-1:0]         row_last,
   output logic [1:0]                               occupancy,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic                                     out_found,
   output logic [gbb_pkg::LEFT_W-1:0]               out_left,
   output logic [gbb_pkg::LEFT_W-1:0]               out_top,
   output logic [gbb_pkg::SIZE_W-1:0]               out_width,
   output logic [gbb_pkg::SIZE_W-1:0]               out_height
);

   import gbb_pkg::*;

   // Stage 2: raw edges
   logic            s2_valid_ff;
   frame_edges_type s2_edges_ff;

   // Stage 3: widened and clamped corners
   logic               s3_valid_ff;
   logic               s3_found_ff;
   logic [COORD_W-1:0] s3_l_ff, s3_t_ff, s3_r_ff, s3_b_ff;
   logic [COORD_W-1:0] l_in, t_in, r_in, b_in;
   logic [COORD_W-1:0] margin;
   logic [SUM_W-1:0]   r_sum, b_sum;

   // Result sizes
   logic [SUM_W-1:0] w_in, h_in;

   // Result register
   logic              out_valid_ff;
   logic              out_found_ff;
   logic [LEFT_W-1:0] out_left_ff;
   logic [LEFT_W-1:0] out_top_ff;
   logic [SIZE_W-1:0] out_width_ff;
   logic [SIZE_W-1:0] out_height_ff;

   logic out_take;
   logic s3_take;
   logic s2_take;

   // Elastic handoff between stages
   assign out_take  = !out_valid_ff || out_ready;
   assign s3_take   = !s3_valid_ff || out_take;
   assign s2_take   = !s2_valid_ff || s3_take;
   assign occupancy = 2'(s2_valid_ff) + 2'(s3_valid_ff) + 2'(out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s2_take) begin
            s2_valid_ff <= frame_done;
         end
         if (s3_take) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_take) begin
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take && frame_done) begin
         s2_edges_ff <= frame_edges;
      end
   end

   // Widen each edge outward and clamp to the frame
   always_comb begin
      margin = COORD_W'(expand_margin);
      l_in   = (s2_edges_ff.left > margin) ? s2_edges_ff.left - margin : '0;
      t_in   = (s2_edges_ff.top > margin) ? s2_edges_ff.top - margin : '0;
      r_sum  = SUM_W'(s2_edges_ff.right) + SUM_W'(margin);
      b_sum  = SUM_W'(s2_edges_ff.bottom) + SUM_W'(margin);
      r_in   = (r_sum > SUM_W'(col_last)) ? col_last : r_sum[COORD_W-1:0];
      b_in   = (b_sum > SUM_W'(row_last)) ? row_last : b_sum[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (s3_take && s2_valid_ff) begin
         s3_found_ff <= s2_edges_ff.found;
         s3_l_ff     <= l_in;
         s3_t_ff     <= t_in;
         s3_r_ff     <= r_in;
         s3_b_ff     <= b_in;
      end
   end

   // Box size from the clamped corners
   always_comb begin
      w_in = (s3_r_ff >= s3_l_ff) ? SUM_W'(s3_r_ff) - SUM_W'(s3_l_ff) + SUM_W'(1) : '0;
      h_in = (s3_b_ff >= s3_t_ff) ? SUM_W'(s3_b_ff) - SUM_W'(s3_t_ff) + SUM_W'(1) : '0;
   end

   // Hold the result until transfer; zero all fields when an edge is missing
   always_ff @(posedge clock) begin
      if (out_take && s3_valid_ff) begin
         out_found_ff <= s3_found_ff;
         if (s3_found_ff) begin
            out_left_ff   <= s3_l_ff[LEFT_W-1:0];
            out_top_ff    <= s3_t_ff[LEFT_W-1:0];
            out_width_ff  <= w_in[SIZE_W-1:0];
            out_height_ff <= h_in[SIZE_W-1:0];
         end else begin
            out_left_ff   <= '0;
            out_top_ff    <= '0;
            out_width_ff  <= '0;
            out_height_ff <= '0;
         end
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_found  = out_found_ff;
   assign out_left   = out_left_ff;
   assign out_top    = out_top_ff;
   assign out_width  = out_width_ff;
   assign out_height = out_height_ff;

   // Admission control upstream must leave room for every finished frame
   a_room_for_frame : assert property (@(posedge clock) disable iff (reset)
      frame_done |-> s2_take)
      else $error("finished frame arrived with stage 2 blocked");

   // A box that lacks any edge carries zero fields
   a_missing_is_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_found_ff) |-> (out_left_ff == '0) && (out_top_ff == '0)
                                    && (out_width_ff == '0) && (out_height_ff == '0))
      else $error("result without edges has nonzero fields");

endmodule : gbb_box_calc

`default_nettype wire

[sv/grid_bounding_box_detector.sv]
// Top level of the grid bounding box detector: registers, admission control, stream ports.
//
// Pixels enter on the req_ stream, one red value per transfer, in raster order
// (row by row, left to right). After the last pixel of a frame, set by the
// image_width and image_height registers, one result leaves on the rsp_
// stream: found on rsp_tuser and the widened box on rsp_tdata.
// Throughput: one pixel per cycle while frames hold two pixels or more and the
// result stream is not stalled. Each pixel is a read-modify-write of one
// column entry in the column RAM (read in the transfer cycle, written the
// next cycle, with forwarding when the same column comes back at once). With
// one-pixel frames every pixel opens a result, and admission is held to the
// three result slots. After the transfer of the last pixel of a frame, the
// result passes memory update, edge widening, size and output before it
// shows on rsp_tvalid. A stalled receiver is absorbed by three result slots;
// req_tready drops only when those slots are all taken or about to be.
// Reset: synchronous, active high; req_tready is low during reset; registers
// return to their defaults (640 x 480, run 60, margin 5, level 125) and the
// raster position to the first pixel. The column RAM is not cleared: its
// entries are seeded by row 0 of every frame. The user writes registers on
// csr_we only while no frame is open; the block does not enforce this.
`default_nettype none

module grid_bounding_box_detector #(
   parameter int MAX_WIDTH  = gbb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gbb_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Configuration write port
   input  wire logic                               csr_we,
   input  wire logic [gbb_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [gbb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Pixel stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [gbb_pkg::PIXEL_W-1:0]        req_tdata,   // [7:0] pixel_red
   // Result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [gbb_pkg::RSP_TDATA_W-1:0]         rsp_tdata,   // [9:0] box_left,
                                                                // [19:10] box_top,
                                                                // [30:20] box_width,
                                                                // [41:31] box_height,
                                                                // [47:42] zero
   output logic [0:0]                              rsp_tuser    // [0] found
);

   import gbb_pkg::*;

   localparam int WD_W = $clog2(MAX_WIDTH + 1);
   localparam int HD_W = $clog2(MAX_HEIGHT + 1);

   // Configuration registers
   logic [DIM_W-1:0]    image_width_ff;
   logic [DIM_W-1:0]    image_height_ff;
   logic [DIM_W-1:0]    run_threshold_ff;
   logic [MARGIN_W-1:0] expand_margin_ff;
   logic [LEVEL_W-1:0]  binarize_level_ff;

   logic [WD_W-1:0]    frame_width;
   logic [HD_W-1:0]    frame_height;
   logic [COORD_W-1:0] col_last;
   logic [COORD_W-1:0] row_last;

   logic            pixel_accept;
   logic            frame_done;
   frame_edges_type frame_edges;
   logic [1:0]      occupancy;
   logic [2:0]      pending;

   logic               out_found;
   logic [LEFT_W-1:0]  out_left;
   logic [LEFT_W-1:0]  out_top;
   logic [SIZE_W-1:0]  out_width;
   logic [SIZE_W-1:0]  out_height;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= RST_IMAGE_WIDTH;
         image_height_ff   <= RST_IMAGE_HEIGHT;
         run_threshold_ff  <= RST_RUN_THRESHOLD;
         expand_margin_ff  <= RST_EXPAND_MARGIN;
         binarize_level_ff <= RST_BINARIZE_LEVEL;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_RUN_THRESHOLD: begin
               run_threshold_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_EXPAND_MARGIN: begin
               expand_margin_ff <= csr_wdata[MARGIN_W-1:0];
            end
            CSR_BINARIZE_LEVEL: begin
               binarize_level_ff <= csr_wdata[LEVEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp frame size to 1 .. maximum
   always_comb begin
      priority if (image_width_ff == '0) begin
         frame_width = WD_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         frame_width = WD_W'(MAX_WIDTH);
      end else begin
         frame_width = WD_W'(image_width_ff);
      end
      priority if (image_height_ff == '0) begin
         frame_height = HD_W'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         frame_height = HD_W'(MAX_HEIGHT);
      end else begin
         frame_height = HD_W'(image_height_ff);
      end
      col_last = COORD_W'(frame_width) - COORD_W'(1);
      row_last = COORD_W'(frame_height) - COORD_W'(1);
   end

   // Admit a pixel only while a result slot is guaranteed for it
   assign pending      = 3'(frame_done) + 3'(occupancy);
   assign req_tready   = !reset && (pending < 3'd3);
   assign pixel_accept = req_tvalid && req_tready;

   gbb_column_unit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_column_unit (
      .clock          (clock),
      .reset          (reset),
      .pixel_accept   (pixel_accept),
      .pixel_red      (req_tdata),
      .binarize_level (binarize_level_ff),
      .run_threshold  (run_threshold_ff),
      .frame_width    (frame_width),
      .frame_height   (frame_height),
      .frame_done     (frame_done),
      .frame_edges    (frame_edges)
   );

   gbb_box_calc u_box_calc (
      .clock         (clock),
      .reset         (reset),
      .frame_done    (frame_done),
      .frame_edges   (frame_edges),
      .expand_margin (expand_margin_ff),
      .col_last      (col_last),
      .row_last      (row_last),
      .occupancy     (occupancy),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_found     (out_found),
      .out_left      (out_left),
      .out_top       (out_top),
      .out_width     (out_width),
      .out_height    (out_height)
   );

   // Pack the result
   assign rsp_tdata = {RSP_PAD_W'(0), out_height, out_width, out_top, out_left};
   assign rsp_tuser = out_found;

endmodule : grid_bounding_box_detector

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for the grid bounding box detector: streamed frames, boxes checked per frame.
module testbench;
   import gbb_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_PIXELS = 1500;
   localparam int CYCLE_LIMIT   = 400000;

   // One finished frame as it leaves on the result stream
   typedef struct packed {
      logic                found;
      logic [LEFT_W-1:0]   left;
      logic [LEFT_W-1:0]   top;
      logic [SIZE_W-1:0]   width;
      logic [SIZE_W-1:0]   height;
   } box_type;

   // What the driver does next: send a pixel, write a register, or wait for quiet
   typedef enum {STEP_PIXEL, STEP_WRITE, STEP_SETTLE} step_kind_type;

   typedef struct {
      step_kind_type             kind;
      logic [CSR_DATA_W-1:0]     value;
      csr_index_type             index;
   } step_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]     csr_addr = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [PIXEL_W-1:0]        req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]    rsp_tdata;
   logic [0:0]                rsp_tuser;

   step_type plan[$];
   box_type  box_queue[$];
   int     open_results = 0;
   bit     stim_done = 1'b0;
   int     cycle_count = 0;
   int     settle_count = 0;
   int     errors = 0;
   int     boxes_checked = 0;
   int     found_boxes = 0;
   int     pixels_taken = 0;

   // Predictor state: registers as seen on the write port, raster position, edges
   int           cfg_width, cfg_height, cfg_threshold, cfg_margin, cfg_level;
   logic [RUN_W-1:0] col_run [DEF_MAX_WIDTH];
   bit           col_qual [DEF_MAX_WIDTH];
   int           col_pos, row_pos;
   int           left_col, right_col, top_row, bottom_row;
   bit           left_ok, right_ok, top_ok, bottom_ok;

   // Stimulus shadow of the effective frame size and level
   int           gen_w, gen_h, gen_level;
   int           gen_pixels = 0;

   bit           idle_on;
   assign idle_on = (cycle_count % 5000) < 3500;

   grid_bounding_box_detector uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int eff_size(input int v, input int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // ---------------------------------------------------------------- predictor

   task automatic clear_frame();
      col_pos = 0;
      row_pos = 0;
      left_col = 0;
      right_col = 0;
      top_row = 0;
      bottom_row = 0;
      left_ok = 1'b0;
      right_ok = 1'b0;
      top_ok = 1'b0;
      bottom_ok = 1'b0;
   endtask

   task automatic apply_write(input csr_index_type index, input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_IMAGE_WIDTH:    cfg_width = int'(value);
         CSR_IMAGE_HEIGHT:   cfg_height = int'(value);
         CSR_RUN_THRESHOLD:  cfg_threshold = int'(value);
         CSR_EXPAND_MARGIN:  cfg_margin = int'(value[MARGIN_W-1:0]);
         CSR_BINARIZE_LEVEL: cfg_level = int'(value[LEVEL_W-1:0]);
         default: ;
      endcase
   endtask

   // Fold one pixel into the column entries and edges; queue a box at frame end
   task automatic take_pixel(input logic [PIXEL_W-1:0] red);
      int      w, h, run, m, l, t, r, b;
      bit      black, qual, last_row, last_col;
      box_type box;
      w = eff_size(cfg_width, DEF_MAX_WIDTH);
      h = eff_size(cfg_height, DEF_MAX_HEIGHT);
      black = int'(red) < cfg_level;
      last_row = row_pos + 1 >= h;
      last_col = col_pos + 1 >= w;
      run = (row_pos == 0) ? 0 : int'(col_run[col_pos]);
      qual = (row_pos == 0) ? 1'b0 : col_qual[col_pos];
      if (black) begin
         run = 0;
      end else begin
         run++;
         if (run >= cfg_threshold) qual = 1'b1;
         if (run > int'(RUN_SAT)) run = int'(RUN_SAT);
      end
      col_run[col_pos] = run[RUN_W-1:0];
      col_qual[col_pos] = qual;
      if (last_row && !qual) begin
         if (!left_ok) begin
            left_col = col_pos;
            left_ok = 1'b1;
         end
         right_col = col_pos;
         right_ok = 1'b1;
      end
      if (black) begin
         if (!top_ok) begin
            top_row = row_pos;
            top_ok = 1'b1;
         end
         bottom_row = row_pos;
         bottom_ok = 1'b1;
      end
      if (!last_col) begin
         col_pos++;
      end else if (!last_row) begin
         col_pos = 0;
         row_pos++;
      end else begin
         box = '0;
         if (left_ok && right_ok && top_ok && bottom_ok) begin
            m = cfg_margin;
            l = (left_col > m) ? left_col - m : 0;
            t = (top_row > m) ? top_row - m : 0;
            r = right_col + m;
            b = bottom_row + m;
            if (r >= w) r = w - 1;
            if (b >= h) b = h - 1;
            box.found = 1'b1;
            box.left = l[LEFT_W-1:0];
            box.top = t[LEFT_W-1:0];
            box.width = (r >= l) ? SIZE_W'(r - l + 1) : '0;
            box.height = (b >= t) ? SIZE_W'(b - t + 1) : '0;
         end
         box_queue.push_back(box);
         clear_frame();
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic push_pixel(input int red);
      step_type s;
      s.kind = STEP_PIXEL;
      s.value = CSR_DATA_W'(red);
      s.index = CSR_IMAGE_WIDTH;
      plan.push_back(s);
      gen_pixels++;
   endtask

   task automatic frame_break();
      step_type s;
      s.kind = STEP_SETTLE;
      s.value = '0;
      s.index = CSR_IMAGE_WIDTH;
      plan.push_back(s);
   endtask

   task automatic set_reg(input csr_index_type index, input int value);
      step_type s;
      s.kind = STEP_WRITE;
      s.value = CSR_DATA_W'(value);
      s.index = index;
      plan.push_back(s);
      case (index)
         CSR_IMAGE_WIDTH:    gen_w = eff_size(value, DEF_MAX_WIDTH);
         CSR_IMAGE_HEIGHT:   gen_h = eff_size(value, DEF_MAX_HEIGHT);
         CSR_BINARIZE_LEVEL: gen_level = value;
         default: ;
      endcase
   endtask

   function automatic int black_value();
      return (gen_level == 0) ? $urandom_range(0, 255) : $urandom_range(0, gen_level - 1);
   endfunction

   function automatic int white_value();
      return $urandom_range(gen_level, 255);
   endfunction

   // One full frame: a dark rectangle on a light background with speckle, or pure noise
   task automatic add_frame();
      int r0, r1, c0, c1;
      bit noise, inner;
      noise = ($urandom_range(0, 3) == 0);
      r0 = $urandom_range(0, gen_h - 1);
      r1 = $urandom_range(r0, gen_h - 1);
      c0 = $urandom_range(0, gen_w - 1);
      c1 = $urandom_range(c0, gen_w - 1);
      for (int r = 0; r < gen_h; r++) begin
         for (int c = 0; c < gen_w; c++) begin
            inner = (r >= r0) && (r <= r1) && (c >= c0) && (c <= c1);
            if (noise) begin
               push_pixel($urandom_range(0, 255));
            end else if (inner == ($urandom_range(0, 99) < 88)) begin
               push_pixel(black_value());
            end else begin
               push_pixel(white_value());
            end
         end
      end
   endtask

   task automatic random_write();
      case ($urandom_range(0, 4))
         0: set_reg(CSR_IMAGE_WIDTH, $urandom_range(0, 14));
         1: set_reg(CSR_IMAGE_HEIGHT, $urandom_range(0, 14));
         2: begin
            if ($urandom_range(0, 7) == 0) set_reg(CSR_RUN_THRESHOLD, $urandom_range(0, 2047));
            else set_reg(CSR_RUN_THRESHOLD, $urandom_range(0, gen_h + 2));
         end
         3: begin
            if ($urandom_range(0, 7) == 0) set_reg(CSR_EXPAND_MARGIN, $urandom_range(0, 1023));
            else set_reg(CSR_EXPAND_MARGIN, $urandom_range(0, 4));
         end
         default: begin
            case ($urandom_range(0, 7))
               0: set_reg(CSR_BINARIZE_LEVEL, 0);
               1: set_reg(CSR_BINARIZE_LEVEL, 255);
               2: set_reg(CSR_BINARIZE_LEVEL, $urandom_range(0, 255));
               default: set_reg(CSR_BINARIZE_LEVEL, $urandom_range(64, 192));
            endcase
         end
      endcase
   endtask

   initial begin
      int start;
      gen_w = eff_size(int'(RST_IMAGE_WIDTH), DEF_MAX_WIDTH);
      gen_h = eff_size(int'(RST_IMAGE_HEIGHT), DEF_MAX_HEIGHT);
      gen_level = int'(RST_BINARIZE_LEVEL);

      // Single pixels: black, white qualifying at once, exactly at level, just below
      frame_break();
      set_reg(CSR_IMAGE_WIDTH, 1);
      set_reg(CSR_IMAGE_HEIGHT, 1);
      set_reg(CSR_RUN_THRESHOLD, 1);
      set_reg(CSR_EXPAND_MARGIN, 0);
      set_reg(CSR_BINARIZE_LEVEL, 125);
      push_pixel(0);
      push_pixel(255);
      push_pixel(125);
      push_pixel(124);

      // Level zero: nothing can be black
      frame_break();
      set_reg(CSR_BINARIZE_LEVEL, 0);
      push_pixel(0);

      // Level 255: only full red is white
      frame_break();
      set_reg(CSR_BINARIZE_LEVEL, 255);
      set_reg(CSR_IMAGE_WIDTH, 2);
      push_pixel(255);
      push_pixel(254);

      // Threshold zero: any white pixel qualifies its column
      frame_break();
      set_reg(CSR_RUN_THRESHOLD, 0);
      set_reg(CSR_IMAGE_WIDTH, 3);
      set_reg(CSR_IMAGE_HEIGHT, 2);
      set_reg(CSR_BINARIZE_LEVEL, 128);
      push_pixel(0);
      push_pixel(200);
      push_pixel(0);
      push_pixel(0);
      push_pixel(0);
      push_pixel(255);

      // Threshold above the frame: no column qualifies; first all white, then one dark pixel
      frame_break();
      set_reg(CSR_RUN_THRESHOLD, 2047);
      set_reg(CSR_IMAGE_WIDTH, 4);
      set_reg(CSR_IMAGE_HEIGHT, 3);
      repeat (12) push_pixel(255);
      frame_break();
      set_reg(CSR_EXPAND_MARGIN, 1023);
      for (int i = 0; i < 12; i++) push_pixel((i == 6) ? 3 : 250);

      // Zero sizes act as one pixel
      frame_break();
      set_reg(CSR_IMAGE_WIDTH, 0);
      set_reg(CSR_IMAGE_HEIGHT, 0);
      set_reg(CSR_EXPAND_MARGIN, 1);
      push_pixel(7);

      // Oversized width acts as the widest row
      frame_break();
      set_reg(CSR_IMAGE_WIDTH, 2047);
      set_reg(CSR_IMAGE_HEIGHT, 1);
      set_reg(CSR_RUN_THRESHOLD, 1);
      set_reg(CSR_EXPAND_MARGIN, 3);
      add_frame();

      // Tallest frame: a full white column reaches a threshold of 1024, its neighbor does not
      frame_break();
      set_reg(CSR_IMAGE_WIDTH, 2);
      set_reg(CSR_IMAGE_HEIGHT, 2047);
      set_reg(CSR_RUN_THRESHOLD, 1024);
      for (int r = 0; r < DEF_MAX_HEIGHT; r++) begin
         push_pixel(255);
         push_pixel((r == 0) ? 0 : 255);
      end

      // Random frames, small sizes, settings changed between frames
      frame_break();
      set_reg(CSR_IMAGE_WIDTH, $urandom_range(1, 14));
      set_reg(CSR_IMAGE_HEIGHT, $urandom_range(1, 14));
      set_reg(CSR_RUN_THRESHOLD, $urandom_range(1, gen_h));
      set_reg(CSR_BINARIZE_LEVEL, $urandom_range(64, 192));
      start = gen_pixels;
      while (gen_pixels - start < RANDOM_PIXELS) begin
         if ($urandom_range(0, 1) == 0) begin
            frame_break();
            repeat ($urandom_range(1, 5)) random_write();
         end
         add_frame();
      end
   end

   // ---------------------------------------------------------------- driver

   // Advance the plan when no pixel is held; settle steps wait for all boxes
   always @(posedge clock) begin : driver
      logic                  nv;
      logic [PIXEL_W-1:0]    nd;
      logic                  nwe;
      logic [CSR_ADDR_W-1:0] na;
      logic [CSR_DATA_W-1:0] nw;
      bit                    took;
      nv = req_tvalid;
      nd = req_tdata;
      nwe = 1'b0;
      na = csr_addr;
      nw = csr_wdata;
      took = req_tvalid && req_tready;
      if (reset) begin
         nv = 1'b0;
         settle_count = 0;
      end else if (!req_tvalid || took) begin
         nv = 1'b0;
         if (plan.size() != 0) begin
            case (plan[0].kind)
               STEP_PIXEL: begin
                  if (!(idle_on && $urandom_range(0, 99) < 20)) begin
                     nv = 1'b1;
                     nd = plan[0].value[PIXEL_W-1:0];
                     void'(plan.pop_front());
                  end
               end
               STEP_WRITE: begin
                  nwe = 1'b1;
                  na = plan[0].index;
                  nw = plan[0].value;
                  void'(plan.pop_front());
               end
               default: begin
                  if (took || open_results != 0) settle_count = 0;
                  else settle_count++;
                  if (settle_count >= SETTLE_CYCLES) begin
                     settle_count = 0;
                     void'(plan.pop_front());
                  end
               end
            endcase
         end
      end
      req_tvalid <= nv;
      req_tdata <= nd;
      csr_we <= nwe;
      csr_addr <= na;
      csr_wdata <= nw;
      stim_done <= (plan.size() == 0) && !nv;
   end

   // Stall the result side at random outside the calm stretches
   always @(posedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(0, 99) >= 20);
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Check result transfers first, then track writes and pixel transfers
   always @(posedge clock) begin : monitor
      box_type want;
      if (reset) begin
         cfg_width = int'(RST_IMAGE_WIDTH);
         cfg_height = int'(RST_IMAGE_HEIGHT);
         cfg_threshold = int'(RST_RUN_THRESHOLD);
         cfg_margin = int'(RST_EXPAND_MARGIN);
         cfg_level = int'(RST_BINARIZE_LEVEL);
         clear_frame();
         box_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (box_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got found=%0d tdata=%h",
                        $time, rsp_tuser[0], rsp_tdata);
            end else begin
               want = box_queue.pop_front();
               check_field("found", int'(want.found), int'(rsp_tuser[0]));
               check_field("box_left", int'(want.left), int'(rsp_tdata[LEFT_W-1:0]));
               check_field("box_top", int'(want.top), int'(rsp_tdata[2*LEFT_W-1:LEFT_W]));
               check_field("box_width", int'(want.width),
                           int'(rsp_tdata[2*LEFT_W+SIZE_W-1:2*LEFT_W]));
               check_field("box_height", int'(want.height),
                           int'(rsp_tdata[RSP_FIELDS_W-1:2*LEFT_W+SIZE_W]));
               boxes_checked++;
               if (want.found) found_boxes++;
            end
         end
         if (csr_we) apply_write(csr_index_type'(csr_addr), csr_wdata);
         if (req_tvalid && req_tready) begin
            take_pixel(req_tdata);
            pixels_taken++;
         end
      end
      open_results <= box_queue.size();
   end

   // ---------------------------------------------------------------- end of run

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      do @(posedge clock);
      while (reset || !stim_done || open_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (box_queue.size() != 0) begin
         errors += box_queue.size();
         $display("%0t: %0d boxes never arrived, expected 0 pending, got %0d",
                  $time, box_queue.size(), box_queue.size());
      end
      $display("Run covered %0d pixels in %0d frames, %0d of them with a box found.",
               pixels_taken, boxes_checked, found_boxes);
      $display("Frames from 1x1 up to 1024 wide and 1024 tall, all registers at extremes.");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
